[rtl/core/mexp_pkg.sv]
// Shared constants, types and helpers for the modular exponentiation block.
package mexp_pkg;

   localparam int FIELD_W = 32;
   localparam int WIDTH   = 32;
   localparam int CNT_W   = $clog2(WIDTH);

   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WIDTH - 1);
   localparam logic [WIDTH-1:0] OP_ZERO   = '0;
   localparam logic [WIDTH-1:0] OP_ONE    = {{(WIDTH-1){1'b0}}, 1'b1};

   typedef logic [WIDTH-1:0] operand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_TEST,
      ST_MULT,
      ST_SQUARE,
      ST_RESP
   } state_type;

   // Request to the shared modular multiplier.
   typedef struct packed {
      logic        start;
      operand_type x;
      operand_type y;
      operand_type m;
   } mul_req_type;

   // Answer from the shared modular multiplier.
   typedef struct packed {
      logic        done;
      operand_type product;
   } mul_rsp_type;

   function automatic logic [FIELD_W-1:0] to_field(input operand_type v);
      to_field = FIELD_W'(v);
   endfunction

endpackage

[rtl/core/mexp_modmul.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module mexp_modmul (
   input  logic                 clock,
   input  logic                 reset,
   input  mexp_pkg::mul_req_type req,
   output mexp_pkg::mul_rsp_type rsp
);

   localparam int W = mexp_pkg::WIDTH;

   logic [W-1:0]                 x_ff, x_in;
   logic [W-1:0]                 y_ff, y_in;
   logic [W-1:0]                 m_ff, m_in;
   logic [W:0]                   m2_ff, m2_in;
   logic [W-1:0]                 r_ff, r_in;
   logic [mexp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [W-1:0]                 addend;
   logic [W+1:0]                 sum;
   logic [W+1:0]                 diff1;
   logic [W+1:0]                 diff2;

   // The running remainder and the multiplicand are both below m, so the
   // doubled-and-added value stays below 3m and at most 2m is taken off.
   always_comb begin
      addend = x_ff[W-1] ? y_ff : mexp_pkg::OP_ZERO;
      sum    = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      diff1  = sum - {2'b00, m_ff};
      diff2  = sum - {1'b0, m2_ff};
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      m2_in   = m2_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         x_in = {x_ff[W-2:0], 1'b0};
         if (sum >= {1'b0, m2_ff}) begin
            r_in = diff2[W-1:0];
         end else if (sum >= {2'b00, m_ff}) begin
            r_in = diff1[W-1:0];
         end else begin
            r_in = sum[W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         x_in    = req.x;
         y_in    = req.y;
         m_in    = req.m;
         m2_in   = {req.m, 1'b0};
         r_in    = mexp_pkg::OP_ZERO;
         cnt_in  = mexp_pkg::CNT_LAST;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      m2_ff  <= m2_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = r_ff;

endmodule

[rtl/core/modular_exponentiation.sv]
// Top level: square-and-multiply sequencer around the shared modular multiplier.
//
// Usage: drive req_base_value, req_exponent and req_modulus and raise start
// while busy is low; that edge accepts the transaction and busy rises. The
// answer appears on rsp_power_result and rsp_modulus_error for exactly one
// cycle, marked by rsp_valid, and busy falls in the following cycle.
// Exponentiation is right to left: the base is first reduced by the modulus,
// then each exponent bit costs one multiply when set and one squaring while
// higher bits remain. All products go through one bit-serial multiplier. With n
// significant exponent bits a transaction takes P = 1 + set bits + n - 1
// products. A zero modulus or a zero exponent is answered in the cycle right
// after the accepting edge. The next transaction can be accepted in the cycle
// after the answer. One transaction is in flight at a time. A zero modulus
// gives 0 with rsp_modulus_error set. Reset returns the sequencer to idle and
// drops any transaction in progress. The receiver cannot stall: each result
// is taken in the cycle it is shown.
module modular_exponentiation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mexp_pkg::FIELD_W-1:0]   req_base_value,
   input  logic [mexp_pkg::FIELD_W-1:0]   req_exponent,
   input  logic [mexp_pkg::FIELD_W-1:0]   req_modulus,
   output logic                           rsp_valid,
   output logic [mexp_pkg::FIELD_W-1:0]   rsp_power_result,
   output logic                           rsp_modulus_error
);

   localparam int W = mexp_pkg::WIDTH;

   mexp_pkg::state_type   state_ff, state_in;
   logic [W-1:0]          e_ff, e_in;
   logic [W-1:0]          m_ff, m_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          sq_ff, sq_in;
   logic [W-1:0]          result_ff, result_in;
   logic                  err_ff, err_in;

   logic [W-1:0]          req_b;
   logic [W-1:0]          req_e;
   logic [W-1:0]          req_m;
   logic [W-1:0]          one_m;
   logic                  more_bits;

   mexp_pkg::mul_req_type mul_req;
   mexp_pkg::mul_rsp_type mul_rsp;

   mexp_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   always_comb begin
      req_b = req_base_value[W-1:0];
      req_e = req_exponent[W-1:0];
      req_m = req_modulus[W-1:0];
      // The multiplier needs operands below the modulus; one reduces to zero
      // when the modulus is one.
      one_m = (req_m == mexp_pkg::OP_ONE) ? mexp_pkg::OP_ZERO : mexp_pkg::OP_ONE;
      more_bits = |e_ff[W-1:1];
   end

   always_comb begin
      state_in  = state_ff;
      e_in      = e_ff;
      m_in      = m_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      result_in = result_ff;
      err_in    = err_ff;
      mul_req.start = 1'b0;
      mul_req.x     = sq_ff;
      mul_req.y     = sq_ff;
      mul_req.m     = m_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            mul_req.x = req_b;
            mul_req.y = one_m;
            mul_req.m = req_m;
            if (start) begin
               if (req_m == mexp_pkg::OP_ZERO) begin
                  result_in = mexp_pkg::OP_ZERO;
                  err_in    = 1'b1;
                  state_in  = mexp_pkg::ST_RESP;
               end else if (req_e == mexp_pkg::OP_ZERO) begin
                  result_in = mexp_pkg::OP_ONE;
                  err_in    = 1'b0;
                  state_in  = mexp_pkg::ST_RESP;
               end else begin
                  mul_req.start = 1'b1;
                  e_in     = req_e;
                  m_in     = req_m;
                  acc_in   = one_m;
                  err_in   = 1'b0;
                  state_in = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               state_in = mexp_pkg::ST_TEST;
            end
         end
         mexp_pkg::ST_TEST: begin
            if (e_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.x     = acc_ff;
               state_in      = mexp_pkg::ST_MULT;
            end else begin
               // The exponent is nonzero here, so a clear low bit implies
               // higher set bits and another squaring.
               e_in          = e_ff >> 1;
               mul_req.start = 1'b1;
               state_in      = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_MULT: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               e_in   = e_ff >> 1;
               if (more_bits) begin
                  mul_req.start = 1'b1;
                  state_in      = mexp_pkg::ST_SQUARE;
               end else begin
                  result_in = mul_rsp.product;
                  state_in  = mexp_pkg::ST_RESP;
               end
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               state_in = mexp_pkg::ST_TEST;
            end
         end
         mexp_pkg::ST_RESP: begin
            state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      m_ff      <= m_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      result_ff <= result_in;
      err_ff    <= err_in;
   end

   assign busy              = (state_ff != mexp_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == mexp_pkg::ST_RESP);
   assign rsp_power_result  = mexp_pkg::to_field(result_ff);
   assign rsp_modulus_error = err_ff;

endmodule
